// ----- rtl/core/gta_pkg.sv -----
// Shared constants, types and the tanh segment table for the GELU activation pipeline.
package gta_pkg;

   localparam int DATA_WIDTH    = 16;
   localparam int FRAC_BITS     = 12;
   localparam int TANH_SEGMENTS = 64;
   localparam int SEG_BITS      = $clog2(TANH_SEGMENTS);

   // Internal magnitudes are unsigned Q24.
   localparam int IQ        = 24;
   localparam int SEG_SHIFT = 26;

   localparam int STAGES = 9;

   // Datapath widths, sized from the largest clamped magnitude of 8.0.
   localparam int MAG_W   = DATA_WIDTH;
   localparam int A_W     = IQ + 4;
   localparam int SQ_W    = 31;
   localparam int CUBE_W  = 34;
   localparam int C_W     = 30;
   localparam int SUM_W   = 31;
   localparam int U_W     = 29;
   localparam int TAB_W   = IQ + 1;
   localparam int R_W     = SEG_SHIFT;
   localparam int F_W     = IQ + 2;
   localparam int PROD_W  = MAG_W + F_W;
   localparam int YMAG_W  = PROD_W - (IQ + 1);

   localparam int CUBE_COEF_W = 20;
   localparam int SQRT_COEF_W = 24;
   localparam logic [CUBE_COEF_W-1:0] CUBE_COEF      = CUBE_COEF_W'(750193);
   localparam logic [SQRT_COEF_W-1:0] SQRT_2_OVER_PI = SQRT_COEF_W'(13386282);

   localparam logic [MAG_W-1:0]  MAG_LIMIT = MAG_W'(8 << FRAC_BITS);
   localparam logic [TAB_W-1:0]  ONE_IQ    = TAB_W'(1) << IQ;
   localparam logic [YMAG_W-1:0] MAX_POS   = YMAG_W'((1 << (DATA_WIDTH - 1)) - 1);
   localparam logic [YMAG_W-1:0] MAX_NEG   = YMAG_W'(1 << (DATA_WIDTH - 1));

   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

   typedef logic [TANH_SEGMENTS:0][TAB_W-1:0] tanh_tab_type;

   typedef struct packed {
      logic [STAGES-1:0] valid;
      logic [STAGES-1:0] load;
   } pipe_ctrl_type;

   // Unsigned long division used while the table is built; it is only ever evaluated at
   // elaboration.
   function automatic logic [63:0] const_div(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Builds the segment end points of tanh on [0,4] in Q24 at elaboration. The exponential
   // is a short series on one sixteenth of the argument, squared four times.
   function automatic tanh_tab_type build_tanh_tab();
      tanh_tab_type tab;
      logic [63:0]  r;
      logic [63:0]  term;
      logic [63:0]  e;
      logic [63:0]  d;
      longint       sum;
      for (int k = 0; k <= TANH_SEGMENTS; k++) begin
         // The segment count is a power of two, so scaling by it and by sixteen is a shift.
         r    = (64'(8 * k) << 30) >> (SEG_BITS + 4);
         term = ONE_Q30;
         sum  = longint'(ONE_Q30);
         for (int n = 1; n <= 12; n++) begin
            term = const_div((term * r) >> 30, 64'(n));
            if ((n & 1) != 0) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         e = (sum < 0) ? 64'd0 : 64'(sum);
         if (e > ONE_Q30) begin
            e = ONE_Q30;
         end
         for (int n = 0; n < 4; n++) begin
            e = (e * e + (ONE_Q30 >> 1)) >> 30;
         end
         if (e > ONE_Q30) begin
            e = ONE_Q30;
         end
         d      = ONE_Q30 + e;
         tab[k] = TAB_W'(const_div(((ONE_Q30 - e) << IQ) + (d >> 1), d));
      end
      return tab;
   endfunction

   localparam tanh_tab_type TANH_TAB = build_tanh_tab();

endpackage

// ----- rtl/core/gta_pipe_ctrl.sv -----
// Valid bits and per-stage load enables for the elastic GELU pipeline.
module gta_pipe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   rsp_stall,
   output gta_pkg::pipe_ctrl_type ctrl
);

   logic [gta_pkg::STAGES-1:0] valid_ff;
   logic [gta_pkg::STAGES-1:0] valid_in;
   logic [gta_pkg::STAGES-1:0] load;

   // A stage may load when it is empty or its beat moves on; bubbles close up this way.
   always_comb begin
      load[gta_pkg::STAGES-1] = !valid_ff[gta_pkg::STAGES-1] || !rsp_stall;
      for (int k = gta_pkg::STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   always_comb begin
      valid_in[0] = load[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < gta_pkg::STAGES; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall  = !load[0];
   assign ctrl.valid = valid_ff;
   assign ctrl.load  = load;

endmodule

// ----- rtl/core/gelu_tanh_activation.sv -----
// Top level of the streaming GELU unit with the tanh approximation, Q4.12 in and out.
//
// Usage: one signed Q4.12 sample enters per beat on the req_ channel together with a
// last flag; one result beat leaves on the rsp_ channel carrying GELU(sample), rounded to
// nearest and saturated, and the same last flag. Beats keep their order.
// Each beat passes through one register per pipeline stage and shows on rsp_valid from
// the last stage, which it leaves when not stalled.
// The stages are magnitude, square, cube, cubic term, tanh argument, table lookup,
// interpolation, final multiply, rounding and saturation.
// Throughput is one beat per cycle unless stalled, set by fully pipelined multipliers.
// Reset clears all valid bits, so the pipeline starts empty; the tanh table is a constant.
// When the receiver stalls, the result holds on the output registers and stages behind
// it keep filling empty slots, so req_stall rises only once every stage holds a beat.
module gelu_tanh_activation (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [gta_pkg::DATA_WIDTH-1:0] req_sample,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [gta_pkg::DATA_WIDTH-1:0] rsp_activation,
   output logic                                rsp_last_out
);

   gta_pkg::pipe_ctrl_type ctrl;

   gta_pipe_ctrl u_pipe_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl)
   );

   // Fields carried along the pipeline, one register per stage.
   logic                      neg_ff  [0:7];
   logic                      last_ff [0:8];
   logic [gta_pkg::MAG_W-1:0] mag_ff  [0:6];
   logic [gta_pkg::A_W-1:0]   a_ff    [0:3];

   logic                      neg_in;
   logic [gta_pkg::MAG_W-1:0] mag_in;
   logic [gta_pkg::MAG_W-1:0] mag_clamped;
   logic [gta_pkg::A_W-1:0]   a_in;

   logic [gta_pkg::SQ_W-1:0]   sq_ff, sq_in;
   logic [gta_pkg::CUBE_W-1:0] cube_ff, cube_in;
   logic [gta_pkg::C_W-1:0]    c_ff, c_in;
   logic [gta_pkg::U_W-1:0]    u_ff, u_in;
   logic                       sat_ff, sat_in;
   logic [gta_pkg::TAB_W-1:0]  lo_ff, lo_in;
   logic [gta_pkg::TAB_W-1:0]  diff_ff, diff_in;
   logic [gta_pkg::R_W-1:0]    r_ff, r_in;
   logic [gta_pkg::F_W-1:0]    f_ff, f_in;
   logic [gta_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [gta_pkg::DATA_WIDTH-1:0] act_ff, act_in;

   logic [2*gta_pkg::A_W-1:0]                        sq_full;
   logic [gta_pkg::SQ_W+gta_pkg::A_W-1:0]            cube_full;
   logic [gta_pkg::CUBE_W+gta_pkg::CUBE_COEF_W-1:0]  c_full;
   logic [gta_pkg::SUM_W-1:0]                        arg_sum;
   logic [gta_pkg::SUM_W+gta_pkg::SQRT_COEF_W-1:0]   u_full;
   logic [gta_pkg::SEG_BITS-1:0]                     seg_idx;
   logic [gta_pkg::TAB_W-1:0]                        hi_val;
   logic [gta_pkg::TAB_W+gta_pkg::R_W-1:0]           interp_full;
   logic [gta_pkg::F_W-1:0]                          t_val;
   logic [gta_pkg::YMAG_W-1:0]                       ymag;

   // Stage 0: magnitude, with the most negative sample giving exactly 2^15.
   always_comb begin
      neg_in      = req_sample[gta_pkg::DATA_WIDTH-1];
      mag_in      = neg_in ? (~req_sample + 1'b1) : req_sample;
      mag_clamped = (mag_in < gta_pkg::MAG_LIMIT) ? mag_in : gta_pkg::MAG_LIMIT;
      a_in        = gta_pkg::A_W'(mag_clamped) << (gta_pkg::IQ - gta_pkg::FRAC_BITS);
   end

   // Stages 1 to 4: polynomial argument of tanh.
   always_comb begin
      sq_full   = a_ff[0] * a_ff[0];
      sq_in     = sq_full[gta_pkg::IQ +: gta_pkg::SQ_W];
      cube_full = sq_ff * a_ff[1];
      cube_in   = cube_full[gta_pkg::IQ +: gta_pkg::CUBE_W];
      c_full    = cube_ff * gta_pkg::CUBE_COEF;
      c_in      = c_full[gta_pkg::IQ +: gta_pkg::C_W];
      arg_sum   = gta_pkg::SUM_W'(a_ff[3]) + gta_pkg::SUM_W'(c_ff);
      u_full    = arg_sum * gta_pkg::SQRT_2_OVER_PI;
      u_in      = u_full[gta_pkg::IQ +: gta_pkg::U_W];
   end

   // Stage 5: segment lookup. An argument of 4.0 or more saturates tanh to one.
   always_comb begin
      sat_in  = (u_ff[gta_pkg::U_W-1:gta_pkg::IQ+2] != '0);
      seg_idx = u_ff[gta_pkg::SEG_SHIFT-1 -: gta_pkg::SEG_BITS];
      lo_in   = gta_pkg::TANH_TAB[seg_idx];
      hi_val  = gta_pkg::TANH_TAB[(gta_pkg::SEG_BITS+1)'(seg_idx) + 1'b1];
      diff_in = (hi_val > lo_in) ? (hi_val - lo_in) : '0;
      r_in    = {u_ff[gta_pkg::SEG_SHIFT-gta_pkg::SEG_BITS-1:0], {gta_pkg::SEG_BITS{1'b0}}};
   end

   // Stage 6: interpolation and the 1 plus or minus tanh factor.
   always_comb begin
      interp_full = diff_ff * r_ff;
      t_val = gta_pkg::F_W'(lo_ff)
            + gta_pkg::F_W'(interp_full[gta_pkg::SEG_SHIFT +: gta_pkg::TAB_W]);
      if (sat_ff || (t_val > gta_pkg::F_W'(gta_pkg::ONE_IQ))) begin
         t_val = gta_pkg::F_W'(gta_pkg::ONE_IQ);
      end
      f_in = neg_ff[5] ? (gta_pkg::F_W'(gta_pkg::ONE_IQ) - t_val)
                       : (gta_pkg::F_W'(gta_pkg::ONE_IQ) + t_val);
   end

   // Stages 7 and 8: scale, round half away from zero, restore the sign and saturate.
   always_comb begin
      prod_in = gta_pkg::PROD_W'(mag_ff[6] * f_ff) + gta_pkg::PROD_W'(gta_pkg::ONE_IQ);
      ymag    = prod_ff[gta_pkg::IQ+1 +: gta_pkg::YMAG_W];
      if (neg_ff[7]) begin
         if (ymag > gta_pkg::MAX_NEG) begin
            ymag = gta_pkg::MAX_NEG;
         end
         act_in = gta_pkg::DATA_WIDTH'(~ymag + 1'b1);
      end else begin
         if (ymag > gta_pkg::MAX_POS) begin
            ymag = gta_pkg::MAX_POS;
         end
         act_in = gta_pkg::DATA_WIDTH'(ymag);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         neg_ff[0]  <= neg_in;
         last_ff[0] <= req_last;
         mag_ff[0]  <= mag_in;
         a_ff[0]    <= a_in;
      end
      for (int k = 1; k < gta_pkg::STAGES; k++) begin
         if (ctrl.load[k]) begin
            last_ff[k] <= last_ff[k-1];
            if (k < 8) begin
               neg_ff[k] <= neg_ff[k-1];
            end
            if (k < 7) begin
               mag_ff[k] <= mag_ff[k-1];
            end
            if (k < 4) begin
               a_ff[k] <= a_ff[k-1];
            end
         end
      end
      if (ctrl.load[1]) begin
         sq_ff <= sq_in;
      end
      if (ctrl.load[2]) begin
         cube_ff <= cube_in;
      end
      if (ctrl.load[3]) begin
         c_ff <= c_in;
      end
      if (ctrl.load[4]) begin
         u_ff <= u_in;
      end
      if (ctrl.load[5]) begin
         sat_ff  <= sat_in;
         lo_ff   <= lo_in;
         diff_ff <= diff_in;
         r_ff    <= r_in;
      end
      if (ctrl.load[6]) begin
         f_ff <= f_in;
      end
      if (ctrl.load[7]) begin
         prod_ff <= prod_in;
      end
      if (ctrl.load[8]) begin
         act_ff <= act_in;
      end
   end

   assign rsp_valid      = ctrl.valid[gta_pkg::STAGES-1];
   assign rsp_activation = act_ff;
   assign rsp_last_out   = last_ff[8];

endmodule
